// ----- rtl/core/sdc_pkg.sv -----
// Shared types and constants of the sprite depth compositor.
// Used by every module under rtl/core except sdc_ram; depends on nothing else.
package sdc_pkg;

    localparam int MAX_COLS  = 128;
    localparam int MAX_ROWS  = 64;
    localparam int MAX_CELLS = 8192;

    localparam int ADDR_W = $clog2(MAX_CELLS);
    localparam int IDX_W  = $clog2(MAX_ROWS * MAX_COLS) + 1;

    // request kinds
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_CLEAR  = 2'd0;
    localparam kind_t KIND_HEADER = 2'd1;
    localparam kind_t KIND_CHAR   = 2'd2;
    localparam kind_t KIND_READ   = 2'd3;

    // configuration registers
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [7:0] SCREEN_WIDTH_RST  = 8'd80;
    localparam logic [6:0] SCREEN_HEIGHT_RST = 7'd25;

    localparam logic [7:0]  BLANK_CHAR  = 8'h20;
    localparam logic [15:0] CLEAR_ORDER = 16'hFFFF;

    typedef logic [ADDR_W-1:0] addr_t;

    typedef struct packed {
        logic [15:0] order;
        logic [15:0] attr;
        logic [7:0]  chr;
    } cell_t;

    localparam int CELL_W = $bits(cell_t);
    localparam cell_t BLANK_CELL = '{order: CLEAR_ORDER, attr: 16'h0000, chr: BLANK_CHAR};

    // one request on its way to the store
    typedef struct packed {
        logic  valid;
        kind_t kind;
        logic  draw;       // character passes visibility and clip tests
        logic  on_screen;  // cell lies on the screen in use
        addr_t addr;
        cell_t wdata;
    } req_t;

    // store status seen by the top level
    typedef struct packed {
        logic clearing;
        logic read_pending;
    } rmw_status_t;

    localparam int RBUF_DEPTH = 3;
    localparam int RBUF_PTR_W = $clog2(RBUF_DEPTH);
    localparam int RBUF_CNT_W = $clog2(RBUF_DEPTH + 1);

endpackage

// ----- rtl/core/sprite_depth_compositor.sv -----
// Top level of the sprite depth compositor: character-cell frame store with depth.
// Depends on sdc_pkg, sdc_issue, sdc_rmw, sdc_rbuf and sdc_ram.
//
//  Channel   Direction  Handshake             Carries
//  s_*       in         s_valid / s_ready     one request: clear, header, character, read
//  m_*       out        m_valid / m_ready     one cell per read request
//  cfg_*     in         cfg_valid / cfg_ready screen_width (index 0), screen_height (index 1)
//
// Header, character and read requests are taken one per cycle while s_ready is
// high; the store does one read and one write per cycle, and a read result
// is registered in the read-modify-write stage and then in the result queue
// before m_valid rises.
// A clear request, and reset, start a sweep over all MAX_CELLS (8192) cells that writes
// one blank cell a cycle; s_ready stays low for its length, cfg_ready stays high.
// A three-entry result queue absorbs m_ready stalls; s_ready drops when it
// cannot take one more read result.
module sprite_depth_compositor (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_kind,
    input  logic signed [8:0]               s_pos_x,
    input  logic signed [7:0]               s_pos_y,
    input  logic [7:0]                      s_sprite_width,
    input  logic [6:0]                      s_sprite_height,
    input  logic [15:0]                     s_color,
    input  logic signed [15:0]              s_draw_order,
    input  logic [7:0]                      s_sprite_char,
    input  logic [6:0]                      s_read_x,
    input  logic [5:0]                      s_read_y,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_cell_char,
    output logic [15:0]                     m_cell_attr,
    output logic signed [15:0]              m_cell_order,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sdc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                      cfg_data
);
    import sdc_pkg::*;

    logic                  s_accept;
    req_t                  req;
    logic                  res_push;
    cell_t                 res_cell;
    rmw_status_t           status;
    cell_t                 out_cell;
    logic [RBUF_CNT_W-1:0] rbuf_count;
    logic [RBUF_CNT_W:0]   reads_owed;

    // take configuration at any time; the user is to write it only while idle, the block does not enforce this
    assign cfg_ready = 1'b1;

    // hold requests during the sweep and while the queue could not take a result
    assign reads_owed = {1'b0, rbuf_count} + (RBUF_CNT_W + 1)'(status.read_pending);
    assign s_ready    = !status.clearing && (reads_owed < (RBUF_CNT_W + 1)'(RBUF_DEPTH));
    assign s_accept   = s_valid && s_ready;

    sdc_issue u_issue (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (s_accept),
        .kind          (s_kind),
        .pos_x         (s_pos_x),
        .pos_y         (s_pos_y),
        .sprite_width  (s_sprite_width),
        .sprite_height (s_sprite_height),
        .color         (s_color),
        .draw_order    (s_draw_order),
        .sprite_char   (s_sprite_char),
        .read_x        (s_read_x),
        .read_y        (s_read_y),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req           (req)
    );

    sdc_rmw u_rmw (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .res_push (res_push),
        .res_cell (res_cell),
        .status   (status)
    );

    sdc_rbuf u_rbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_cell (res_cell),
        .pop       (m_valid && m_ready),
        .out_valid (m_valid),
        .out_cell  (out_cell),
        .count     (rbuf_count)
    );

    assign m_cell_char  = out_cell.chr;
    assign m_cell_attr  = out_cell.attr;
    assign m_cell_order = out_cell.order;

    a_hold_during_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        status.clearing |-> !s_ready)
        else $error("request accepted during clearing sweep");

endmodule

// ----- rtl/core/sdc_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// Standalone; no package dependency.
module sdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/sdc_issue.sv -----
// Request issue: screen registers, sprite header, cursor and cell address.
// Depends on sdc_pkg.
module sdc_issue (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept,
    input  sdc_pkg::kind_t                  kind,
    input  logic [8:0]                      pos_x,
    input  logic [7:0]                      pos_y,
    input  logic [7:0]                      sprite_width,
    input  logic [6:0]                      sprite_height,
    input  logic [15:0]                     color,
    input  logic [15:0]                     draw_order,
    input  logic [7:0]                      sprite_char,
    input  logic [6:0]                      read_x,
    input  logic [5:0]                      read_y,
    input  logic                            cfg_write,
    input  logic [sdc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                      cfg_data,
    output sdc_pkg::req_t                   req
);
    import sdc_pkg::*;

    logic [7:0]  screen_width_reg,  screen_width_next;
    logic [6:0]  screen_height_reg, screen_height_next;
    logic [8:0]  hdr_start_x_reg,   hdr_start_x_next;
    logic [7:0]  hdr_start_y_reg,   hdr_start_y_next;
    logic [7:0]  hdr_width_reg,     hdr_width_next;
    logic [6:0]  hdr_height_reg,    hdr_height_next;
    logic [15:0] hdr_color_reg,     hdr_color_next;
    logic [15:0] hdr_order_reg,     hdr_order_next;
    logic [7:0]  cursor_col_reg,    cursor_col_next;
    logic [6:0]  cursor_row_reg,    cursor_row_next;

    logic [8:0]       w_eff;
    logic [7:0]       h_eff;
    logic [10:0]      char_x, cell_x;
    logic [9:0]       char_y, cell_y;
    logic             char_active;
    logic             on_screen;
    logic [IDX_W-1:0] idx_full;
    logic [8:0]       col_inc;

    // clamp the screen to the store size
    assign w_eff = ({1'b0, screen_width_reg} > 9'(MAX_COLS)) ? 9'(MAX_COLS)
                                                              : {1'b0, screen_width_reg};
    assign h_eff = ({1'b0, screen_height_reg} > 8'(MAX_ROWS)) ? 8'(MAX_ROWS)
                                                               : {1'b0, screen_height_reg};

    assign char_x = {{2{hdr_start_x_reg[8]}}, hdr_start_x_reg} + {3'b000, cursor_col_reg};
    assign char_y = {{2{hdr_start_y_reg[7]}}, hdr_start_y_reg} + {3'b000, cursor_row_reg};

    assign char_active = (hdr_width_reg != 8'd0) && (hdr_height_reg != 7'd0)
                      && (cursor_row_reg < hdr_height_reg);

    always_comb begin
        if (kind == KIND_READ) begin
            cell_x = {4'b0000, read_x};
            cell_y = {4'b0000, read_y};
        end else begin
            cell_x = char_x;
            cell_y = char_y;
        end
    end

    assign idx_full = IDX_W'(cell_y[8:0]) * IDX_W'(MAX_COLS) + IDX_W'(cell_x[9:0]);
    assign on_screen = !cell_x[10] && !cell_y[9]
                    && (cell_x[9:0] < {1'b0, w_eff})
                    && (cell_y[8:0] < {1'b0, h_eff})
                    && (idx_full < IDX_W'(MAX_CELLS));

    always_comb begin
        req.valid     = accept;
        req.kind      = kind;
        req.on_screen = on_screen;
        req.draw      = (kind == KIND_CHAR) && char_active && on_screen
                     && (sprite_char != BLANK_CHAR);
        req.addr      = idx_full[ADDR_W-1:0];
        req.wdata     = '{order: hdr_order_reg, attr: hdr_color_reg, chr: sprite_char};
    end

    assign col_inc = {1'b0, cursor_col_reg} + 9'd1;

    always_comb begin
        screen_width_next  = screen_width_reg;
        screen_height_next = screen_height_reg;
        hdr_start_x_next   = hdr_start_x_reg;
        hdr_start_y_next   = hdr_start_y_reg;
        hdr_width_next     = hdr_width_reg;
        hdr_height_next    = hdr_height_reg;
        hdr_color_next     = hdr_color_reg;
        hdr_order_next     = hdr_order_reg;
        cursor_col_next    = cursor_col_reg;
        cursor_row_next    = cursor_row_reg;

        if (cfg_write) begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  screen_width_next  = cfg_data;
                REG_SCREEN_HEIGHT: screen_height_next = cfg_data[6:0];
                default: ;
            endcase
        end

        if (accept && kind == KIND_HEADER) begin
            hdr_start_x_next = pos_x;
            hdr_start_y_next = pos_y;
            hdr_width_next   = sprite_width;
            hdr_height_next  = sprite_height;
            hdr_color_next   = color;
            hdr_order_next   = draw_order;
            cursor_col_next  = 8'd0;
            cursor_row_next  = 7'd0;
        end else if (accept && kind == KIND_CHAR && char_active) begin
            // advance the cursor, wrap to the next row at the sprite edge
            if (col_inc >= {1'b0, hdr_width_reg}) begin
                cursor_col_next = 8'd0;
                cursor_row_next = cursor_row_reg + 7'd1;
            end else begin
                cursor_col_next = col_inc[7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
            hdr_start_x_reg   <= '0;
            hdr_start_y_reg   <= '0;
            hdr_width_reg     <= '0;
            hdr_height_reg    <= '0;
            hdr_color_reg     <= '0;
            hdr_order_reg     <= '0;
            cursor_col_reg    <= '0;
            cursor_row_reg    <= '0;
        end else begin
            screen_width_reg  <= screen_width_next;
            screen_height_reg <= screen_height_next;
            hdr_start_x_reg   <= hdr_start_x_next;
            hdr_start_y_reg   <= hdr_start_y_next;
            hdr_width_reg     <= hdr_width_next;
            hdr_height_reg    <= hdr_height_next;
            hdr_color_reg     <= hdr_color_next;
            hdr_order_reg     <= hdr_order_next;
            cursor_col_reg    <= cursor_col_next;
            cursor_row_reg    <= cursor_row_next;
        end
    end

endmodule

// ----- rtl/core/sdc_rmw.sv -----
// Cell store read-modify-write stage, write forwarding and clearing sweep.
// Depends on sdc_pkg and sdc_ram.
module sdc_rmw (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sdc_pkg::req_t        req,
    output logic                 res_push,
    output sdc_pkg::cell_t       res_cell,
    output sdc_pkg::rmw_status_t status
);
    import sdc_pkg::*;

    req_t  s1_reg, s1_next;
    logic  clr_busy_reg, clr_busy_next;
    addr_t clr_addr_reg, clr_addr_next;
    logic  lw_valid_reg, lw_valid_next;
    addr_t lw_addr_reg,  lw_addr_next;
    cell_t lw_data_reg,  lw_data_next;

    logic              ram_we;
    addr_t             ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [CELL_W-1:0] ram_rdata;
    cell_t             cur_cell;
    logic              s1_write;

    sdc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (MAX_CELLS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (req.addr),
        .rdata (ram_rdata)
    );

    // the previous write lands at the same edge as this read: forward it
    assign cur_cell = (lw_valid_reg && lw_addr_reg == s1_reg.addr) ? lw_data_reg
                                                                   : cell_t'(ram_rdata);

    assign s1_write = s1_reg.valid && s1_reg.draw
                   && ($signed(cur_cell.order) <= $signed(s1_reg.wdata.order));

    always_comb begin
        if (clr_busy_reg) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = BLANK_CELL;
        end else begin
            ram_we    = s1_write;
            ram_waddr = s1_reg.addr;
            ram_wdata = s1_reg.wdata;
        end
    end

    always_comb begin
        s1_next       = req;
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        lw_valid_next = lw_valid_reg;
        lw_addr_next  = lw_addr_reg;
        lw_data_next  = lw_data_reg;

        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + addr_t'(1);
            if (clr_addr_reg == addr_t'(MAX_CELLS - 1)) begin
                clr_busy_next = 1'b0;
            end
            lw_valid_next = 1'b0;
        end else if (req.valid && req.kind == KIND_CLEAR) begin
            clr_busy_next = 1'b1;
            clr_addr_next = '0;
        end

        if (!clr_busy_reg && s1_write) begin
            lw_valid_next = 1'b1;
            lw_addr_next  = s1_reg.addr;
            lw_data_next  = s1_reg.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            lw_valid_reg <= 1'b0;
        end else begin
            s1_reg       <= s1_next;
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
            lw_valid_reg <= lw_valid_next;
        end
        lw_addr_reg <= lw_addr_next;
        lw_data_reg <= lw_data_next;
    end

    assign res_push = s1_reg.valid && s1_reg.kind == KIND_READ;
    assign res_cell = s1_reg.on_screen ? cur_cell : BLANK_CELL;

    assign status.clearing     = clr_busy_reg;
    assign status.read_pending = res_push;

    a_clear_starts_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        req.valid && req.kind == KIND_CLEAR |=> clr_busy_reg)
        else $error("clear request did not start the sweep");

    a_sweep_owns_port: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !(s1_reg.valid && s1_reg.draw))
        else $error("character write collides with clearing sweep");

endmodule

// ----- rtl/core/sdc_rbuf.sv -----
// Result queue between the cell store and the result channel.
// Depends on sdc_pkg.
module sdc_rbuf (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             push,
    input  sdc_pkg::cell_t                   push_cell,
    input  logic                             pop,
    output logic                             out_valid,
    output sdc_pkg::cell_t                   out_cell,
    output logic [sdc_pkg::RBUF_CNT_W-1:0]   count
);
    import sdc_pkg::*;

    cell_t                 entry_reg [RBUF_DEPTH];
    logic [RBUF_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RBUF_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RBUF_CNT_W-1:0] count_reg,  count_next;

    function automatic logic [RBUF_PTR_W-1:0] ptr_inc(input logic [RBUF_PTR_W-1:0] p);
        ptr_inc = (p == RBUF_PTR_W'(RBUF_DEPTH - 1)) ? '0 : p + RBUF_PTR_W'(1);
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + RBUF_CNT_W'(push) - RBUF_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cell;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_cell  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |-> count_reg != RBUF_CNT_W'(RBUF_DEPTH))
        else $error("result queue overflow");

endmodule
